/* design/dpbd_pkg.sv */
// Shared types and constants for the DAQ packet byte decoder.
package dpbd_pkg;

	// Packet layout.
	localparam int MODULES_PER_PACKET = 4;
	localparam logic [7:0] HEADER_BYTE = 8'h80;
	localparam logic [7:0] FIRST_ADC_BYTE = 8'd9;
	localparam logic [7:0] FIXED_BYTES = 8'd10;
	localparam logic [7:0] BYTES_PER_MODULE = 8'd32;
	localparam logic [7:0] COUNT_MAX = 8'd255;
	localparam logic [3:0] MODULE_MASK = 4'((1 << MODULES_PER_PACKET) - 1);

	// Field widths.
	localparam int BYTE_W = 8;
	localparam int ADC_W = 12;
	localparam int HALF_W = 6;
	localparam int INDEX_W = 6;
	localparam int TIME_W = 42;
	localparam int TIME_GROUP_W = 7;
	localparam int OUT_DATA_W = 80;

	// Kind of result item, carried on the output tuser.
	localparam logic ITEM_ADC = 1'b0;
	localparam logic ITEM_SUMMARY = 1'b1;

	// Summary status codes.
	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_HEADER = 2'd1,
		STATUS_NO_TRIGGER = 2'd2,
		STATUS_BAD_LENGTH = 2'd3
	} status_t;

	// One result item plus a flag saying whether the byte produced one.
	typedef struct packed {
		logic                 produced;
		logic                 item_kind;
		logic [ADC_W-1:0]     adc_sample;
		logic [INDEX_W-1:0]   adc_index;
		status_t              status;
		logic [4:0]           backend_id;
		logic [1:0]           board_id;
		logic [1:0]           fpga_number;
		logic                 chip_number;
		logic [3:0]           trigger_mask;
		logic [2:0]           modules_triggered;
		logic [TIME_W-1:0]    timestamp;
	} result_t;

endpackage

/* design/dpbd_in_reg.sv */
// Input register stage: captures one packet byte per transfer.
module dpbd_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dpbd_pkg::BYTE_W-1:0] s_tdata,
	input  logic                       s_tlast,
	input  logic                       out_free,
	output logic                       advance,
	output logic                       valid_s1,
	output logic [dpbd_pkg::BYTE_W-1:0] byte_s1,
	output logic                       eop_s1
);
	import dpbd_pkg::*;

	// The held byte moves on whenever the result register can take its result.
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eop_s1  <= s_tlast;
		end
	end

endmodule

/* design/dpbd_parser.sv */
// Packet state and the single-pass decode of one byte into a result.
module dpbd_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [dpbd_pkg::BYTE_W-1:0] byte_s1,
	input  logic                       eop_s1,
	output dpbd_pkg::result_t          result
);
	import dpbd_pkg::*;

	logic [7:0]              byte_count_q;
	logic                    header_bad_q;
	logic [4:0]              backend_q;
	logic [1:0]              board_q;
	logic [1:0]              fpga_q;
	logic                    chip_q;
	logic [3:0]              trigger_q;
	logic [TIME_W-1:0]       time_q;
	logic [HALF_W-1:0]       upper_q;
	logic [INDEX_W-1:0]      value_count_q;

	logic [7:0]              byte_count_d;
	logic                    header_bad_d;
	logic [4:0]              backend_d;
	logic [1:0]              board_d;
	logic [1:0]              fpga_d;
	logic                    chip_d;
	logic [3:0]              trigger_d;
	logic [TIME_W-1:0]       time_d;
	logic [HALF_W-1:0]       upper_d;
	logic [INDEX_W-1:0]      value_count_d;
	logic [2:0]              nmod;
	logic [7:0]              expected_len;
	status_t                 status;

	// Decode one byte against the packet state; the summary uses the updated state.
	always_comb begin
		byte_count_d  = byte_count_q;
		header_bad_d  = header_bad_q;
		backend_d     = backend_q;
		board_d       = board_q;
		fpga_d        = fpga_q;
		chip_d        = chip_q;
		trigger_d     = trigger_q;
		time_d        = time_q;
		upper_d       = upper_q;
		value_count_d = value_count_q;
		result        = '0;

		if (byte_count_q == 8'd0) begin
			header_bad_d  = (byte_s1 != HEADER_BYTE);
			backend_d     = '0;
			board_d       = '0;
			fpga_d        = '0;
			chip_d        = 1'b0;
			trigger_d     = '0;
			time_d        = '0;
			upper_d       = '0;
			value_count_d = '0;
		end else if (byte_count_q == 8'd1) begin
			backend_d = byte_s1[6:2];
			board_d   = byte_s1[1:0];
		end else if (byte_count_q == 8'd2) begin
			fpga_d    = byte_s1[5:4];
			chip_d    = byte_s1[6];
			trigger_d = byte_s1[3:0] & MODULE_MASK;
		end else if (byte_count_q < FIRST_ADC_BYTE) begin
			time_d = {time_q[TIME_W-TIME_GROUP_W-1:0], byte_s1[TIME_GROUP_W-1:0]};
		end else if (!eop_s1 && byte_count_q < COUNT_MAX) begin
			// Odd positions carry the upper half, even positions complete a value.
			if (byte_count_q[0]) begin
				upper_d = byte_s1[HALF_W-1:0];
			end else begin
				if (!header_bad_q && trigger_q != 4'd0) begin
					result.produced   = 1'b1;
					result.item_kind  = ITEM_ADC;
					result.adc_sample = {upper_q, byte_s1[HALF_W-1:0]};
					result.adc_index  = value_count_q;
				end
				value_count_d = value_count_q + INDEX_W'(1);
			end
		end

		if (byte_count_q != COUNT_MAX) begin
			byte_count_d = byte_count_q + 8'd1;
		end

		nmod = 3'({2'b0, trigger_d[0]} + {2'b0, trigger_d[1]}
			+ {2'b0, trigger_d[2]} + {2'b0, trigger_d[3]});
		expected_len = FIXED_BYTES + 8'(BYTES_PER_MODULE * {5'b0, nmod});

		if (header_bad_d) begin
			status = STATUS_BAD_HEADER;
		end else if (trigger_d == 4'd0) begin
			status = STATUS_NO_TRIGGER;
		end else if (byte_count_d != expected_len) begin
			status = STATUS_BAD_LENGTH;
		end else begin
			status = STATUS_OK;
		end

		// Summary on the end mark, then the packet state starts over.
		if (eop_s1) begin
			result           = '0;
			result.produced  = 1'b1;
			result.item_kind = ITEM_SUMMARY;
			result.status    = status;
			if (status != STATUS_BAD_HEADER) begin
				result.backend_id  = backend_d;
				result.board_id    = board_d;
				result.fpga_number = fpga_d;
				result.chip_number = chip_d;
			end
			if (status == STATUS_OK || status == STATUS_BAD_LENGTH) begin
				result.trigger_mask      = trigger_d;
				result.modules_triggered = nmod;
			end
			if (status == STATUS_OK) begin
				result.timestamp = time_d;
			end
			byte_count_d  = '0;
			header_bad_d  = 1'b0;
			backend_d     = '0;
			board_d       = '0;
			fpga_d        = '0;
			chip_d        = 1'b0;
			trigger_d     = '0;
			time_d        = '0;
			upper_d       = '0;
			value_count_d = '0;
		end
	end

	// Packet state, updated as each byte leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			header_bad_q  <= 1'b0;
			backend_q     <= '0;
			board_q       <= '0;
			fpga_q        <= '0;
			chip_q        <= 1'b0;
			trigger_q     <= '0;
			time_q        <= '0;
			upper_q       <= '0;
			value_count_q <= '0;
		end else if (advance) begin
			byte_count_q  <= byte_count_d;
			header_bad_q  <= header_bad_d;
			backend_q     <= backend_d;
			board_q       <= board_d;
			fpga_q        <= fpga_d;
			chip_q        <= chip_d;
			trigger_q     <= trigger_d;
			time_q        <= time_d;
			upper_q       <= upper_d;
			value_count_q <= value_count_d;
		end
	end

endmodule

/* design/dpbd_out_reg.sv */
// Result register: holds one result item until the downstream transfer.
module dpbd_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  dpbd_pkg::result_t               result,
	output logic                            out_free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dpbd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tuser
);
	import dpbd_pkg::*;

	logic    valid_q;
	result_t item_q;

	// The register can load when empty or when its item leaves this cycle.
	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= advance && result.produced;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && out_free) begin
			item_q <= result;
		end
	end

	// Pack the fields, lowest first, one pad bit at the top.
	assign m_tvalid = valid_q;
	assign m_tuser  = item_q.item_kind;
	assign m_tdata  = {1'b0, item_q.timestamp, item_q.modules_triggered,
		item_q.trigger_mask, item_q.chip_number, item_q.fpga_number,
		item_q.board_id, item_q.backend_id, item_q.status,
		item_q.adc_index, item_q.adc_sample};

endmodule

/* design/daq_packet_byte_decoder.sv */
// Top level of the DAQ packet byte decoder.
//
//   Channel | Direction | Contents
//   s_      | in        | tdata[7:0] byte_value, tlast end_of_packet
//   m_      | out       | tuser item_kind; tdata fields listed at the port
//
// One byte is taken every cycle unless the output stalls while the result
// register is full. A byte is held in the input register while the parser
// decodes it; its result, if any, is loaded into the result register as the
// byte leaves the input register, and is offered from the result register.
// Reset clears the packet state and both valid flags. A stall on the output
// stops the input stage only while the result register is full.
module daq_packet_byte_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] byte_value
	input  logic                            s_tlast,  // end_of_packet
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [11:0] adc_sample, [17:12] adc_index, [19:18] status,
	// [24:20] backend_id, [26:25] board_id, [28:27] fpga_number,
	// [29] chip_number, [33:30] trigger_mask, [36:34] modules_triggered,
	// [78:37] timestamp, [79] zero
	output logic [dpbd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                            m_tuser   // [0] item_kind
);
	import dpbd_pkg::*;

	logic                 out_free;
	logic                 advance;
	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 eop_s1;
	result_t              result;

	dpbd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.out_free (out_free),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.eop_s1   (eop_s1)
	);

	dpbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.eop_s1  (eop_s1),
		.result  (result)
	);

	dpbd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// An ADC item carries only its value and index.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ITEM_ADC |-> m_tdata[78:18] == '0)
	else $error("ADC item carries summary fields");

	// A summary never carries ADC value or index.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ITEM_SUMMARY |-> m_tdata[17:0] == '0)
	else $error("summary item carries ADC fields");

	// A bad-header summary reports no information fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ITEM_SUMMARY && m_tdata[19:18] == STATUS_BAD_HEADER
		|-> m_tdata[78:20] == '0)
	else $error("bad-header summary reports fields");

	// The module count always matches the reported trigger mask.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $countones(m_tdata[33:30]) == int'(m_tdata[36:34]))
	else $error("module count does not match trigger mask");

	// The input stage only holds its byte while the result register is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> m_tvalid && !m_tready)
	else $error("input stage stalled without output stall");

endmodule
